[rtl/core/tmc_pkg.sv]
// Shared types and constants of the tempo-map tick/sample converter.
package tmc_pkg;

    localparam int NUM_BASE_W = 75;
    localparam int DIV_W      = 42;
    localparam int DEN_W      = 35;

    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;
    localparam logic [26:0] BPM_NUMER     = 27'd120000000;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;
    localparam logic [13:0] BPM_MAX       = 14'h3FFF;
    localparam logic [14:0] TPB_RESET     = 15'd96;
    localparam logic [17:0] SR_RESET      = 18'd48000;
    localparam logic [DEN_W-1:0] DEN_RESET = 35'd96000000;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_T2S    = 2'd1,
        OP_S2T    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_ORDER = 3'd2,
        ST_ZERO  = 3'd3,
        ST_SAT   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_LOOK, S_GO, S_WAIT, S_FIN, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        STEP_DT_TEMPO, STEP_TIMES_SR, STEP_SEG_DIV, STEP_BPM_DIV,
        STEP_OFF_D, STEP_TEMPO_SR, STEP_TICK_DIV
    } t_step;

    typedef struct packed {
        logic [31:0]      tick;
        logic [23:0]      tempo;
        logic [39:0]      whole;
        logic [DEN_W-1:0] frac;
    } t_entry;

    typedef struct packed {
        logic         start;
        logic         is_div;
    } t_arith_ctl;

endpackage

[rtl/core/tmc_cfg.sv]
// APB register file holding ticks per beat and sample rate, plus the derived denominator.
module tmc_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic [17:0]              o_sample_rate,
    output logic [tmc_pkg::DEN_W-1:0] o_denom
);
    import tmc_pkg::*;

    logic [14:0]      r_tpb;
    logic [17:0]      r_sr;
    logic [DEN_W-1:0] r_denom;
    logic [14:0]      w_tpb_eff;
    logic             w_wr;

    assign w_wr      = psel && penable && pwrite;
    assign w_tpb_eff = (pwdata[14:0] == 15'd0) ? 15'd1 : pwdata[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb   <= TPB_RESET;
            r_sr    <= SR_RESET;
            r_denom <= DEN_RESET;
        end else if (w_wr) begin
            if (paddr[2]) begin
                r_sr <= pwdata[17:0];
            end else begin
                r_tpb   <= pwdata[14:0];
                r_denom <= DEN_W'(w_tpb_eff) * DEN_W'(US_PER_SEC);
            end
        end
    end

    assign prdata        = paddr[2] ? {14'd0, r_sr} : {17'd0, r_tpb};
    assign pready        = 1'b1;
    assign o_sample_rate = r_sr;
    assign o_denom       = r_denom;
endmodule

[rtl/core/tmc_mem.sv]
// Tempo map storage: one write port, one read port with a registered read.
module tmc_mem #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(DEPTH)-1:0]    i_waddr,
    input  tmc_pkg::t_entry             i_wdata,
    input  logic [$clog2(DEPTH)-1:0]    i_raddr,
    output tmc_pkg::t_entry             o_rdata
);
    import tmc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/tmc_arith.sv]
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module tmc_arith #(
    parameter int NUM_W = 91
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tmc_pkg::t_arith_ctl       i_ctl,
    input  logic [NUM_W-1:0]          i_a,
    input  logic [tmc_pkg::DIV_W-1:0] i_b,
    output logic                      o_done,
    output logic [NUM_W-1:0]          o_result,
    output logic [tmc_pkg::DIV_W-1:0] o_rem
);
    import tmc_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_is_div;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_x;
    logic [NUM_W-1:0] r_acc;
    logic [DIV_W-1:0] r_y;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W:0]   w_trial;
    logic             w_fits;

    assign w_trial = {r_rem, r_x[NUM_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy   <= 1'b1;
                r_is_div <= i_ctl.is_div;
                r_cnt    <= i_ctl.is_div ? CW'(NUM_W) : CW'(DIV_W);
                r_x      <= i_a;
                r_y      <= i_b;
                r_acc    <= '0;
                r_rem    <= '0;
            end else if (r_busy) begin
                if (r_is_div) begin
                    if (w_fits) begin
                        r_rem <= DIV_W'(w_trial - {1'b0, r_y});
                        r_x   <= {r_x[NUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[DIV_W-1:0];
                        r_x   <= {r_x[NUM_W-2:0], 1'b0};
                    end
                end else begin
                    if (r_y[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= {r_x[NUM_W-2:0], 1'b0};
                    r_y <= {1'b0, r_y[DIV_W-1:1]};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_is_div ? r_x : r_acc;
    assign o_rem    = r_rem;
endmodule

[rtl/core/tempo_map_tick_sample_converter_top.sv]
// Top level: command sequencer that walks the tempo map and drives the arithmetic unit.
// Clear goes straight to the result; a rejected append ends after the map lookup;
// a sample query whose tempo times sample rate is zero skips the final division.
// NUM_W = 75 + FRACTION_BITS is the width of the bit-serial unit. Commands are taken
// one at a time: busy stays high until the result.
// Reset: synchronous; the map returns at once to the single default point.
module tempo_map_tick_sample_converter_top #(
    parameter int MAP_DEPTH     = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_tick,
    input  logic [23:0] i_tempo_us,
    input  logic [39:0] i_query_sample,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [39:0] o_sample_out,
    output logic [47:0] o_tick_fixed,
    output logic [6:0]  o_bpm_low,
    output logic [6:0]  o_bpm_high,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tmc_pkg::*;

    localparam int NUM_W = NUM_BASE_W + FRACTION_BITS;
    localparam int AW    = $clog2(MAP_DEPTH);
    localparam int CNT_W = $clog2(MAP_DEPTH + 1);

    t_state          r_state, n_state;
    t_step           r_step;
    t_op             r_op;
    logic [31:0]     r_tick;
    logic [23:0]     r_tempo;
    logic [39:0]     r_qs;
    logic [CNT_W-1:0] r_count;
    logic            r_only_default;
    logic            r_e0_dflt;
    logic [AW-1:0]   r_idx;
    t_entry          r_sel;
    logic [NUM_W-1:0] r_acc;
    logic [DIV_W-1:0] r_div;
    logic [39:0]     r_w;
    logic [DEN_W-1:0] r_f;
    t_status         r_status;
    logic [39:0]     r_sample;
    logic [47:0]     r_tickfx;
    logic [13:0]     r_bpm;

    logic [17:0]      w_sr;
    logic [DEN_W-1:0] w_denom;
    t_entry           w_mem_rd, w_ent, w_wdata;
    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr, w_last;
    t_arith_ctl       w_actl;
    logic [NUM_W-1:0] w_a, w_res;
    logic [DIV_W-1:0] w_b, w_rem;
    logic             w_adone;
    logic             w_accept;
    logic [31:0]      w_dt;
    logic             w_app_rej, w_app_repl, w_scan_stop;
    logic             w_s2t_pass;
    logic [NUM_W-1:0] w_base, w_q_fin, w_max48;
    logic             w_fin_sat;
    logic [47:0]      w_fin_sum;

    tmc_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_sample_rate(w_sr), .o_denom(w_denom)
    );

    tmc_mem #(.DEPTH(MAP_DEPTH)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_mem_rd)
    );

    tmc_arith #(.NUM_W(NUM_W)) u_arith (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_actl), .i_a(w_a), .i_b(w_b),
        .o_done(w_adone), .o_result(w_res), .o_rem(w_rem)
    );

    assign w_accept = start && !busy;
    assign w_last   = AW'(r_count - CNT_W'(1));
    assign w_raddr  = r_idx;

    // Entry 0 reads as the default point until it is first overwritten.
    always_comb begin
        w_ent = w_mem_rd;
        if (r_idx == '0 && r_e0_dflt) begin
            w_ent.tick  = '0;
            w_ent.tempo = DEFAULT_TEMPO;
            w_ent.whole = '0;
            w_ent.frac  = '0;
        end
    end

    assign w_dt       = r_tick - r_sel.tick;
    assign w_app_repl = (r_tempo != 24'd0) && r_only_default && (r_tick == 32'd0);
    assign w_app_rej  = (r_tempo == 24'd0) ||
                        (!w_app_repl && ((r_tick < w_ent.tick) ||
                                         (r_count >= CNT_W'(MAP_DEPTH))));
    assign w_s2t_pass = !((w_ent.whole > r_qs) ||
                          ((w_ent.whole == r_qs) && (w_ent.frac != '0)));
    always_comb begin
        w_scan_stop = (r_idx == w_last);
        if (r_op == OP_T2S && w_ent.tick > r_tick) begin
            w_scan_stop = 1'b1;
        end
        if (r_op == OP_S2T && !w_s2t_pass) begin
            w_scan_stop = 1'b1;
        end
    end

    // Final tick: base plus quotient, saturating at 48 bits.
    assign w_base    = NUM_W'(r_sel.tick) << FRACTION_BITS;
    assign w_max48   = NUM_W'(MAX48);
    assign w_q_fin   = (r_step == STEP_TICK_DIV) ? w_res : '0;
    assign w_fin_sat = (w_base > w_max48) || (w_q_fin > (w_max48 - w_base));
    assign w_fin_sum = 48'(w_base + w_q_fin);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_op) == OP_CLEAR) ? S_OUT : S_RD;
                end
            end
            S_RD: n_state = S_LOOK;
            S_LOOK: begin
                if (r_op == OP_APPEND) begin
                    n_state = w_app_rej ? S_OUT : S_GO;
                end else begin
                    n_state = w_scan_stop ? S_GO : S_RD;
                end
            end
            S_GO: n_state = S_WAIT;
            S_WAIT: begin
                if (w_adone) begin
                    case (r_step)
                        STEP_SEG_DIV:  n_state = S_FIN;
                        STEP_BPM_DIV:  n_state = S_OUT;
                        STEP_TICK_DIV: n_state = S_OUT;
                        STEP_TEMPO_SR: n_state = (w_res == '0) ? S_OUT : S_GO;
                        default:       n_state = S_GO;
                    endcase
                end
            end
            S_FIN:   n_state = (r_op == OP_APPEND) ? S_GO : S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy          = (r_state != S_IDLE);
        o_done        = (r_state == S_OUT);
        w_actl.start  = (r_state == S_GO);
        w_actl.is_div = (r_step == STEP_SEG_DIV) || (r_step == STEP_BPM_DIV) ||
                        (r_step == STEP_TICK_DIV);
        w_we          = 1'b0;
        w_waddr       = '0;
        w_wdata.tick  = r_tick;
        w_wdata.tempo = r_tempo;
        w_wdata.whole = r_w;
        w_wdata.frac  = r_f;
        if (r_state == S_LOOK && r_op == OP_APPEND && w_app_repl) begin
            w_we          = 1'b1;
            w_wdata.tick  = '0;
            w_wdata.whole = '0;
            w_wdata.frac  = '0;
        end else if (r_state == S_FIN && r_op == OP_APPEND) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
        end
        case (r_step)
            STEP_DT_TEMPO: begin
                w_a = NUM_W'(w_dt);
                w_b = DIV_W'(r_sel.tempo);
            end
            STEP_TIMES_SR: begin
                w_a = r_acc;
                w_b = DIV_W'(w_sr);
            end
            STEP_SEG_DIV: begin
                w_a = r_acc;
                w_b = DIV_W'(w_denom);
            end
            STEP_BPM_DIV: begin
                w_a = NUM_W'(BPM_NUMER) + NUM_W'(r_tempo);
                w_b = DIV_W'({r_tempo, 1'b0});
            end
            STEP_OFF_D: begin
                w_a = NUM_W'(r_qs - r_sel.whole);
                w_b = DIV_W'(w_denom);
            end
            STEP_TEMPO_SR: begin
                w_a = NUM_W'(r_sel.tempo);
                w_b = DIV_W'(w_sr);
            end
            STEP_TICK_DIV: begin
                w_a = r_acc;
                w_b = r_div;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= CNT_W'(1);
            r_only_default <= 1'b1;
            r_e0_dflt      <= 1'b1;
            r_step         <= STEP_DT_TEMPO;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= t_op'(i_op);
                        r_tick   <= i_tick;
                        r_tempo  <= i_tempo_us;
                        r_qs     <= i_query_sample;
                        r_status <= ST_OK;
                        r_sample <= '0;
                        r_tickfx <= '0;
                        r_bpm    <= '0;
                        r_idx    <= (t_op'(i_op) == OP_APPEND) ? w_last : '0;
                        if (t_op'(i_op) == OP_CLEAR) begin
                            r_count        <= CNT_W'(1);
                            r_only_default <= 1'b1;
                            r_e0_dflt      <= 1'b1;
                        end
                    end
                end
                S_LOOK: begin
                    if (r_op == OP_APPEND) begin
                        if (r_tempo == 24'd0) begin
                            r_status <= ST_ZERO;
                        end else if (w_app_repl) begin
                            r_only_default <= 1'b0;
                            r_e0_dflt      <= 1'b0;
                            r_step         <= STEP_BPM_DIV;
                        end else if (r_tick < w_ent.tick) begin
                            r_status <= ST_ORDER;
                        end else if (r_count >= CNT_W'(MAP_DEPTH)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_sel  <= w_ent;
                            r_step <= STEP_DT_TEMPO;
                        end
                    end else begin
                        // Entries are in tick order; the last qualifying one wins.
                        if ((r_op == OP_T2S && w_ent.tick <= r_tick) ||
                            (r_op == OP_S2T && w_s2t_pass)) begin
                            r_sel <= w_ent;
                        end
                        if (!w_scan_stop) begin
                            r_idx <= r_idx + AW'(1);
                        end
                        r_step <= (r_op == OP_T2S) ? STEP_DT_TEMPO : STEP_OFF_D;
                    end
                end
                S_WAIT: begin
                    if (w_adone) begin
                        case (r_step)
                            STEP_DT_TEMPO: begin
                                r_acc  <= w_res;
                                r_step <= STEP_TIMES_SR;
                            end
                            STEP_TIMES_SR: begin
                                r_acc  <= w_res + NUM_W'(r_sel.frac);
                                r_step <= STEP_SEG_DIV;
                            end
                            STEP_SEG_DIV: begin
                                if (w_res > NUM_W'(MAX40 - r_sel.whole)) begin
                                    r_w      <= MAX40;
                                    r_f      <= '0;
                                    r_status <= ST_SAT;
                                end else begin
                                    r_w <= r_sel.whole + w_res[39:0];
                                    r_f <= w_rem[DEN_W-1:0];
                                end
                            end
                            STEP_BPM_DIV: begin
                                if (w_res == '0) begin
                                    r_bpm <= 14'd1;
                                end else if (w_res > NUM_W'(BPM_MAX)) begin
                                    r_bpm <= BPM_MAX;
                                end else begin
                                    r_bpm <= w_res[13:0];
                                end
                            end
                            STEP_OFF_D: begin
                                if (w_res < NUM_W'(r_sel.frac)) begin
                                    r_acc <= '0;
                                end else begin
                                    r_acc <= (w_res - NUM_W'(r_sel.frac)) << FRACTION_BITS;
                                end
                                r_step <= STEP_TEMPO_SR;
                            end
                            STEP_TEMPO_SR: begin
                                r_div  <= w_res[DIV_W-1:0];
                                r_step <= STEP_TICK_DIV;
                                // A zero divisor leaves only the base, or saturates.
                                if (w_res == '0) begin
                                    if (r_acc != '0 || w_fin_sat) begin
                                        r_tickfx <= MAX48;
                                        r_status <= ST_SAT;
                                    end else begin
                                        r_tickfx <= w_fin_sum;
                                    end
                                end
                            end
                            STEP_TICK_DIV: begin
                                if (w_fin_sat) begin
                                    r_tickfx <= MAX48;
                                    r_status <= ST_SAT;
                                end else begin
                                    r_tickfx <= w_fin_sum;
                                end
                            end
                            default: r_step <= STEP_DT_TEMPO;
                        endcase
                    end
                end
                S_FIN: begin
                    // Round half up against the segment denominator.
                    if ({r_f, 1'b0} >= {1'b0, w_denom}) begin
                        if (r_w == MAX40) begin
                            r_sample <= r_w;
                            r_status <= ST_SAT;
                        end else begin
                            r_sample <= r_w + 40'd1;
                        end
                    end else begin
                        r_sample <= r_w;
                    end
                    if (r_op == OP_APPEND) begin
                        r_count        <= r_count + CNT_W'(1);
                        r_only_default <= 1'b0;
                        r_step         <= STEP_BPM_DIV;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status     = r_status;
    assign o_sample_out = r_sample;
    assign o_tick_fixed = r_tickfx;
    assign o_bpm_low    = r_bpm[6:0];
    assign o_bpm_high   = r_bpm[13:7];

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without a result strobe");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_W'(MAP_DEPTH)))
        else $error("map point count out of range");
    a_arith_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adone |-> (r_state == S_WAIT))
        else $error("arithmetic result arrived while not waiting");
    a_write_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CNT_W'(w_waddr) <= r_count))
        else $error("map write beyond the next free entry");
`endif
endmodule
